// ===== rtl/core/dpds_pkg.sv =====
package dpds_pkg;

   localparam int unsigned POS_W   = 24;
   localparam int unsigned ERR_W   = POS_W + 1;
   localparam int unsigned DERIV_W = ERR_W + 1;
   localparam int unsigned INTEG_W = 32;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned MAG_W   = 7;
   localparam int unsigned POWER_W = MAG_W + 1;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned PHASE_W = 7;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam int unsigned PT_W  = ERR_W + GAIN_W + 1;
   localparam int unsigned DT_W  = DERIV_W + GAIN_W + 1;
   localparam int unsigned IT_W  = INTEG_W + GAIN_W + 1;
   localparam int unsigned SUM_W = IT_W + 2;

   localparam logic signed [ERR_W-1:0] SAMPLED_RESET = 25'sd100;
   localparam logic [MAG_W-1:0] CATAPULT_FULL = 7'd127;
   localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_TICKS   = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_OUTPUT_CAP     = 3'd4,
      CSR_MIN_OUTPUT     = 3'd5,
      CSR_TIMEOUT_TICKS  = 3'd6,
      CSR_INTEGRAL_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] target_ticks;
      logic [GAIN_W-1:0]       gain_p;
      logic [GAIN_W-1:0]       gain_i;
      logic [GAIN_W-1:0]       gain_d;
      logic [MAG_W-1:0]        output_cap;
      logic [MAG_W-1:0]        min_output;
      logic [TICK_W-1:0]       timeout_ticks;
      logic signed [POS_W-1:0] integral_limit;
   } cfg_type;

   typedef struct packed {
      logic                      done;
      logic                      timed_out;
      logic                      catapult_on;
      logic signed [ERR_W-1:0]   err;
      logic signed [DERIV_W-1:0] deriv;
      logic signed [INTEG_W-1:0] integ;
   } trk_type;

   typedef struct packed {
      logic                   done;
      logic                   timed_out;
      logic                   catapult_on;
      logic signed [PT_W-1:0] p_term;
      logic signed [DT_W-1:0] d_term;
      logic signed [IT_W-1:0] i_term;
   } prod_type;

endpackage

// ===== rtl/core/dpds_req_if.sv =====
interface dpds_req_if;
   import dpds_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    restart;
   logic signed [POS_W-1:0] measured_ticks;
   logic                    limit_pressed;

   modport source (output valid, restart, measured_ticks, limit_pressed, input ready);
   modport sink (input valid, restart, measured_ticks, limit_pressed, output ready);
endinterface

// ===== rtl/core/dpds_rsp_if.sv =====
interface dpds_rsp_if;
   import dpds_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POWER_W-1:0] drive_power;
   logic [MAG_W-1:0]          catapult_power;
   logic                      done_res;
   logic                      timed_out;

   modport source (output valid, drive_power, catapult_power, done_res, timed_out,
                   input ready);
   modport sink (input valid, drive_power, catapult_power, done_res, timed_out,
                 output ready);
endinterface

// ===== rtl/core/dpds_csr_if.sv =====
interface dpds_csr_if;
   import dpds_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dpds_track.sv =====
module dpds_track
   import dpds_pkg::*;
#(
   parameter int unsigned SETTLE_PERIOD = 100,
   parameter int unsigned SETTLE_WINDOW = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    fire,
   input  logic                    restart,
   input  logic signed [POS_W-1:0] measured_ticks,
   input  logic                    limit_pressed,
   output trk_type                 trk
);

   localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(SETTLE_PERIOD);
   localparam logic signed [ERR_W-1:0] WINDOW = ERR_W'(SETTLE_WINDOW);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   logic signed [ERR_W-1:0]   prev_ff, prev_in, prev_e;
   logic signed [INTEG_W-1:0] integ_ff, integ_in, integ_e;
   logic [TICK_W-1:0]         tick_ff, tick_in, tick_e;
   logic [PHASE_W-1:0]        phase_ff, phase_in, phase_e, phase_inc;
   logic signed [ERR_W-1:0]   samp_ff, samp_in, samp_e;
   logic                      fin_ff, fin_in, fin_e;
   logic                      tout_ff, tout_in, tout_e;

   logic signed [ERR_W-1:0]     err;
   logic signed [DERIV_W-1:0]   deriv;
   logic signed [INTEG_W:0]     isum;
   logic signed [INTEG_W-1:0]   isat, integ_n;
   logic signed [ERR_W-1:0]     limit_x;

   always_comb begin
      prev_e  = restart ? '0 : prev_ff;
      integ_e = restart ? '0 : integ_ff;
      tick_e  = restart ? '0 : tick_ff;
      phase_e = restart ? '0 : phase_ff;
      samp_e  = restart ? SAMPLED_RESET : samp_ff;
      fin_e   = restart ? 1'b0 : fin_ff;
      tout_e  = restart ? 1'b0 : tout_ff;

      err     = ERR_W'(cfg.target_ticks) - ERR_W'(measured_ticks);
      deriv   = DERIV_W'(err) - DERIV_W'(prev_e);
      isum    = (INTEG_W+1)'(integ_e) + (INTEG_W+1)'(err);
      if (isum[INTEG_W] != isum[INTEG_W-1]) begin
         isat = isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         isat = isum[INTEG_W-1:0];
      end
      limit_x = ERR_W'(cfg.integral_limit);
      if (err == '0 || err > limit_x || isat > INTEG_W'(err)) begin
         integ_n = '0;
      end else begin
         integ_n = isat;
      end

      prev_in  = prev_e;
      integ_in = integ_e;
      tick_in  = tick_e;
      phase_in = phase_e;
      samp_in  = samp_e;
      fin_in   = fin_e;
      tout_in  = tout_e;
      phase_inc = phase_e + 1'b1;

      if (!fin_e) begin
         prev_in  = err;
         integ_in = integ_n;
         if (tick_e > cfg.timeout_ticks) begin
            fin_in  = 1'b1;
            tout_in = 1'b1;
         end else begin
            if (tick_e != TICK_MAX) begin
               tick_in = tick_e + 1'b1;
            end
            phase_in = phase_inc;
            if (phase_inc == PERIOD) begin
               phase_in = '0;
               samp_in  = err;
            end
            if (samp_in <= WINDOW && samp_in >= -WINDOW) begin
               fin_in = 1'b1;
            end
         end
      end

      trk.done        = fin_in;
      trk.timed_out   = tout_in;
      trk.catapult_on = !limit_pressed;
      trk.err         = err;
      trk.deriv       = deriv;
      trk.integ       = integ_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         integ_ff <= '0;
         tick_ff  <= '0;
         phase_ff <= '0;
         samp_ff  <= SAMPLED_RESET;
         fin_ff   <= 1'b0;
         tout_ff  <= 1'b0;
      end else if (fire) begin
         prev_ff  <= prev_in;
         integ_ff <= integ_in;
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
         samp_ff  <= samp_in;
         fin_ff   <= fin_in;
         tout_ff  <= tout_in;
      end
   end

endmodule

// ===== rtl/core/dpds_gain.sv =====
module dpds_gain
   import dpds_pkg::*;
(
   input  trk_type  trk,
   input  cfg_type  cfg,
   output prod_type prod
);

   always_comb begin
      prod.done        = trk.done;
      prod.timed_out   = trk.timed_out;
      prod.catapult_on = trk.catapult_on;
      prod.p_term = PT_W'(trk.err) * PT_W'($signed({1'b0, cfg.gain_p}));
      prod.d_term = DT_W'(trk.deriv) * DT_W'($signed({1'b0, cfg.gain_d}));
      prod.i_term = IT_W'(trk.integ) * IT_W'($signed({1'b0, cfg.gain_i}));
   end

endmodule

// ===== rtl/core/dpds_shape.sv =====
module dpds_shape
   import dpds_pkg::*;
#(
   parameter int unsigned GAIN_FRAC_BITS = 8
) (
   input  prod_type                  prod,
   input  logic [MAG_W-1:0]          output_cap,
   input  logic [MAG_W-1:0]          min_output,
   output logic signed [POWER_W-1:0] power
);

   localparam logic signed [SUM_W-1:0] SUM_ZERO = '0;

   logic signed [SUM_W-1:0] sum, capv, minv, clamped, mag_full;
   logic [SUM_W-1:0]        shifted;
   logic [MAG_W-1:0]        mag;
   logic                    neg;

   always_comb begin
      sum  = SUM_W'(prod.p_term) + SUM_W'(prod.d_term) + SUM_W'(prod.i_term);
      capv = $signed(SUM_W'(output_cap) << GAIN_FRAC_BITS);
      minv = $signed(SUM_W'(min_output) << GAIN_FRAC_BITS);
      clamped = sum;
      if (clamped > capv) begin
         clamped = capv;
      end
      if (clamped < -capv) begin
         clamped = -capv;
      end
      if (clamped > SUM_ZERO && clamped < minv) begin
         clamped = minv;
      end
      if (clamped < SUM_ZERO && clamped > -minv) begin
         clamped = -minv;
      end
      neg      = clamped[SUM_W-1];
      mag_full = neg ? -clamped : clamped;
      shifted  = $unsigned(mag_full) >> GAIN_FRAC_BITS;
      mag      = shifted[MAG_W-1:0];
      power    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

endmodule

// ===== rtl/core/distance_pid_drive_step_top.sv =====
// PID drive step for a distance move. One control tick is accepted per clock cycle
// unless rsp backpressure stalls the pipe, and its result passes through the input
// register, the tracking stage that updates the error, integral, tick count and settle
// sample, the product stage with the three gain multipliers, then the clamp/min shaping
// into the output register. Sustained rate is one transaction per cycle without
// backpressure. Backpressure on rsp stalls only the stages behind it.
// Configuration writes are always accepted and must only occur while the block is idle.
module distance_pid_drive_step_top
   import dpds_pkg::*;
#(
   parameter int unsigned SETTLE_PERIOD  = 100,
   parameter int unsigned SETTLE_WINDOW  = 13,
   parameter int unsigned GAIN_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   dpds_req_if.sink    req,
   dpds_rsp_if.source  rsp,
   dpds_csr_if.sink    csr
);

   cfg_type cfg_ff;

   logic                    v0_ff, v1_ff, v2_ff, v3_ff;
   logic                    adv0, adv1, adv2, adv3;
   logic                    restart_ff;
   logic signed [POS_W-1:0] meas_ff;
   logic                    limit_ff;
   trk_type                 trk_in, trk_ff;
   prod_type                prod_in, prod_ff;
   logic signed [POWER_W-1:0] power_in;
   logic signed [POWER_W-1:0] drive_ff;
   logic [MAG_W-1:0]        cat_ff;
   logic                    done_ff, tout_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_ticks   <= '0;
         cfg_ff.gain_p         <= 16'd77;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= 16'd512;
         cfg_ff.output_cap     <= 7'd127;
         cfg_ff.min_output     <= 7'd15;
         cfg_ff.timeout_ticks  <= 16'd900;
         cfg_ff.integral_limit <= '0;
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_TARGET_TICKS:   cfg_ff.target_ticks   <= $signed(csr.data[POS_W-1:0]);
            CSR_GAIN_P:         cfg_ff.gain_p         <= csr.data[GAIN_W-1:0];
            CSR_GAIN_I:         cfg_ff.gain_i         <= csr.data[GAIN_W-1:0];
            CSR_GAIN_D:         cfg_ff.gain_d         <= csr.data[GAIN_W-1:0];
            CSR_OUTPUT_CAP:     cfg_ff.output_cap     <= csr.data[MAG_W-1:0];
            CSR_MIN_OUTPUT:     cfg_ff.min_output     <= csr.data[MAG_W-1:0];
            CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr.data[TICK_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= $signed(csr.data[POS_W-1:0]);
            default: ;
         endcase
      end
   end

   assign adv3 = !v3_ff || rsp.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign adv0 = !v0_ff || adv1;
   assign req.ready = adv0;

   dpds_track #(
      .SETTLE_PERIOD (SETTLE_PERIOD),
      .SETTLE_WINDOW (SETTLE_WINDOW)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .fire           (v0_ff && adv1),
      .restart        (restart_ff),
      .measured_ticks (meas_ff),
      .limit_pressed  (limit_ff),
      .trk            (trk_in)
   );

   dpds_gain u_gain (
      .trk  (trk_ff),
      .cfg  (cfg_ff),
      .prod (prod_in)
   );

   dpds_shape #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_shape (
      .prod       (prod_ff),
      .output_cap (cfg_ff.output_cap),
      .min_output (cfg_ff.min_output),
      .power      (power_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req.valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0 && req.valid) begin
         restart_ff <= req.restart;
         meas_ff    <= req.measured_ticks;
         limit_ff   <= req.limit_pressed;
      end
      if (adv1 && v0_ff) begin
         trk_ff <= trk_in;
      end
      if (adv2 && v1_ff) begin
         prod_ff <= prod_in;
      end
      if (adv3 && v2_ff) begin
         drive_ff <= prod_ff.done ? '0 : power_in;
         cat_ff   <= (prod_ff.done || !prod_ff.catapult_on) ? '0 : CATAPULT_FULL;
         done_ff  <= prod_ff.done;
         tout_ff  <= prod_ff.timed_out;
      end
   end

   assign rsp.valid          = v3_ff;
   assign rsp.drive_power    = drive_ff;
   assign rsp.catapult_power = cat_ff;
   assign rsp.done_res       = done_ff;
   assign rsp.timed_out      = tout_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.done_res |-> rsp.drive_power == '0 && rsp.catapult_power == '0)
      else $error("finished move drives outputs");

   a_tout_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.timed_out |-> rsp.done_res)
      else $error("timeout without done");

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.drive_power != {1'b1, {(POWER_W-1){1'b0}}})
      else $error("drive power out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp.ready && v2_ff |=> v2_ff && v3_ff)
      else $error("pipeline dropped a transaction under backpressure");

endmodule
